[rtl/core/shift_insert_array_macros.svh]
// Assertion macros used by the checker file of this block.
`ifndef SHIFT_INSERT_ARRAY_MACROS_SVH
`define SHIFT_INSERT_ARRAY_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SIA_ASSERT_NOW(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("shift_insert_array: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define SIA_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("shift_insert_array: next-cycle check failed");

`endif

[rtl/core/sia_pkg.sv]
package sia_pkg;

    // Default capacity and the longest burst of words one view may return.
    localparam int DEPTH_DEFAULT = 16;
    localparam int MAX_RESULTS   = 16;

    // Fixed field widths.
    localparam int OP_W     = 3;
    localparam int POS_W    = 4;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 5;
    localparam int MR_W     = $clog2(MAX_RESULTS + 1);

    // Packed widths of the stream data buses, rounded up to whole bytes.
    localparam int S_TDATA_W = ((POS_W + VALUE_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((VALUE_W + OCC_W + 7) / 8) * 8;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 3'd0,
        OP_INSERT = 3'd1,
        OP_EDIT   = 3'd2,
        OP_DELETE = 3'd3,
        OP_VIEW   = 3'd4
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_BAD_INDEX = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic exec;        // apply the accepted word and load its single result
        logic view_start;  // rewind the view pointer
        logic view_emit;   // load the next stored entry into the output register
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;    // output register is empty or being drained
        logic count_zero;  // array holds no entries
        logic view_last;   // view pointer sits on the final entry to stream
    } dp_stat_t;

endpackage

[rtl/core/sia_ctrl.sv]
module sia_ctrl
    import sia_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [OP_W-1:0] s_op,
    input  dp_stat_t        stat,
    output dp_cmd_t         cmd
);

    typedef enum logic {
        S_IDLE,
        S_VIEW
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;
    logic   is_view;

    // A new word is taken only between views and while the output register can load.
    assign s_tready = (state_reg == S_IDLE) && stat.out_free;
    assign accept   = s_tvalid && s_tready;
    assign is_view  = (op_t'(s_op) == OP_VIEW);

    // A view of a non-empty array is streamed by the sequencer; all else completes at once.
    always_comb begin
        cmd.exec       = accept && !(is_view && !stat.count_zero);
        cmd.view_start = accept && is_view && !stat.count_zero;
        cmd.view_emit  = (state_reg == S_VIEW) && stat.out_free;
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (cmd.view_start) begin
                    state_next = S_VIEW;
                end
            end
            S_VIEW: begin
                if (cmd.view_emit && stat.view_last) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[rtl/core/sia_datapath.sv]
module sia_datapath
    import sia_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic                aclk,
    input  logic                aresetn,
    input  dp_cmd_t             cmd,
    output dp_stat_t            stat,
    input  logic [OP_W-1:0]     s_op,
    input  logic [POS_W-1:0]    s_pos,
    input  logic [VALUE_W-1:0]  s_value,
    input  logic                m_tready,
    output logic                m_tvalid,
    output logic [STATUS_W-1:0] m_status,
    output logic [VALUE_W-1:0]  m_element,
    output logic [OCC_W-1:0]    m_occupancy,
    output logic                m_tlast
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int VW    = (CNT_W > MR_W) ? CNT_W : MR_W;

    logic [VALUE_W-1:0]  entries_reg [DEPTH];
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;
    logic [IDX_W-1:0]    idx_reg;
    logic                valid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [VALUE_W-1:0]  element_reg;
    logic [OCC_W-1:0]    occ_reg;
    logic                last_reg;

    logic [CMP_W-1:0]    pos_ext;
    logic [CMP_W-1:0]    cnt_ext;
    status_t             status_calc;
    logic                do_append;
    logic                do_insert;
    logic                do_edit;
    logic                do_delete;
    logic [VW-1:0]       view_n;
    logic [VW-1:0]       view_pos;

    assign pos_ext = CMP_W'(s_pos);
    assign cnt_ext = CMP_W'(count_reg);

    // Result status of the offered operation against the current fill level.
    always_comb begin
        status_calc = ST_OK;
        case (op_t'(s_op))
            OP_APPEND: begin
                if (cnt_ext >= CMP_W'(DEPTH)) status_calc = ST_FULL;
            end
            OP_INSERT: begin
                if (pos_ext > cnt_ext) begin
                    status_calc = ST_BAD_INDEX;
                end else if (cnt_ext >= CMP_W'(DEPTH)) begin
                    status_calc = ST_FULL;
                end
            end
            OP_EDIT: begin
                if (pos_ext >= cnt_ext) status_calc = ST_BAD_INDEX;
            end
            OP_DELETE: begin
                if (count_reg == '0) begin
                    status_calc = ST_EMPTY;
                end else if (pos_ext >= cnt_ext) begin
                    status_calc = ST_BAD_INDEX;
                end
            end
            OP_VIEW: status_calc = ST_EMPTY;
            default: status_calc = ST_BAD_INDEX;
        endcase
    end

    // Write strobes, only for a successful operation.
    always_comb begin
        do_append = cmd.exec && (status_calc == ST_OK) && (op_t'(s_op) == OP_APPEND);
        do_insert = cmd.exec && (status_calc == ST_OK) && (op_t'(s_op) == OP_INSERT);
        do_edit   = cmd.exec && (status_calc == ST_OK) && (op_t'(s_op) == OP_EDIT);
        do_delete = cmd.exec && (status_calc == ST_OK) && (op_t'(s_op) == OP_DELETE);
    end

    always_comb begin
        count_next = count_reg;
        if (do_append || do_insert) begin
            count_next = count_reg + 1'b1;
        end else if (do_delete) begin
            count_next = count_reg - 1'b1;
        end
    end

    // One storage cell per entry; each takes its own word, its lower or its upper neighbor.
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        localparam int PREV = (g == 0) ? 0 : g - 1;
        localparam int NEXT = (g == DEPTH - 1) ? g : g + 1;
        localparam logic [CMP_W-1:0] G_POS = CMP_W'(g);

        always_ff @(posedge aclk) begin
            if (do_append && (G_POS == cnt_ext)) begin
                entries_reg[g] <= s_value;
            end else if (do_insert && (G_POS == pos_ext)) begin
                entries_reg[g] <= s_value;
            end else if (do_insert && (G_POS > pos_ext) && (G_POS <= cnt_ext)) begin
                entries_reg[g] <= entries_reg[PREV];
            end else if (do_edit && (G_POS == pos_ext)) begin
                entries_reg[g] <= s_value;
            end else if (do_delete && (G_POS >= pos_ext) && (G_POS + 1'b1 < cnt_ext)) begin
                entries_reg[g] <= entries_reg[NEXT];
            end
        end
    end

    // A view streams at most MAX_RESULTS entries.
    assign view_n   = (VW'(count_reg) > VW'(MAX_RESULTS)) ? VW'(MAX_RESULTS) : VW'(count_reg);
    assign view_pos = VW'(idx_reg) + 1'b1;

    always_comb begin
        stat.out_free   = !valid_reg || m_tready;
        stat.count_zero = (count_reg == '0);
        stat.view_last  = (view_pos == view_n);
    end

    // Fill level and view pointer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            idx_reg   <= '0;
        end else begin
            count_reg <= count_next;
            if (cmd.view_start) begin
                idx_reg <= '0;
            end else if (cmd.view_emit) begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    // Output register: holds one result word until the receiver takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (cmd.exec || cmd.view_emit) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.exec) begin
            status_reg  <= status_calc;
            element_reg <= '0;
            occ_reg     <= OCC_W'(count_next);
            last_reg    <= 1'b1;
        end else if (cmd.view_emit) begin
            status_reg  <= ST_OK;
            element_reg <= entries_reg[idx_reg];
            occ_reg     <= OCC_W'(count_reg);
            last_reg    <= stat.view_last;
        end
    end

    assign m_tvalid    = valid_reg;
    assign m_status    = status_reg;
    assign m_element   = element_reg;
    assign m_occupancy = occ_reg;
    assign m_tlast     = last_reg;

endmodule

[rtl/core/shift_insert_array.sv]
// Ordered array of signed 32-bit words driven by a stream of operation words.
//
// Input channel (s_*): s_tuser carries the operation (append, insert, edit,
// delete, view), s_tdata carries the position and the value. Output channel
// (m_*): s_tuser's counterpart m_tuser carries the status, m_tdata the element
// and the occupancy, m_tlast marks the final result of an operation.
//
// Append, insert, edit, delete and a view of an empty array each produce one
// result word in the cycle after acceptance, and a new word can be accepted in
// every cycle while the receiver keeps up. Insert and delete shift the entries
// from the position upward in the register array in that same cycle.
// A view of a non-empty array first rewinds the read pointer, then loads one
// result per stored entry (at most 16), each once the output register is free,
// read through the single read port of the array. No new word is accepted
// until the last view result has been loaded.
// Reset empties the array and drops m_tvalid. When the receiver stalls, the
// output register holds its word and s_tready falls until it drains.
module shift_insert_array
    import sia_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // position [3:0], value [35:4], zero fill
    input  logic [OP_W-1:0]      s_tuser,   // operation [2:0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // element [31:0], occupancy [36:32], zero fill
    output logic [STATUS_W-1:0]  m_tuser,   // status [1:0]
    output logic                 m_tlast
);

    dp_cmd_t            cmd;
    dp_stat_t           stat;
    logic [VALUE_W-1:0] m_element;
    logic [OCC_W-1:0]   m_occupancy;

    sia_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_op     (s_tuser),
        .stat     (stat),
        .cmd      (cmd)
    );

    sia_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .s_op        (s_tuser),
        .s_pos       (s_tdata[POS_W-1:0]),
        .s_value     (s_tdata[POS_W+VALUE_W-1:POS_W]),
        .m_tready    (m_tready),
        .m_tvalid    (m_tvalid),
        .m_status    (m_tuser),
        .m_element   (m_element),
        .m_occupancy (m_occupancy),
        .m_tlast     (m_tlast)
    );

    // Pack the result word.
    assign m_tdata = M_TDATA_W'({m_occupancy, m_element});

endmodule

[rtl/core/sia_checker.sv]
`include "shift_insert_array_macros.svh"

module sia_checker
    import sia_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
)
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [STATUS_W-1:0]  m_tuser,
    input logic                 m_tlast
);

    logic err_word;

    assign err_word = m_tvalid && (m_tuser != ST_OK);

    // A failed operation reports no element.
    `SIA_ASSERT_NOW(a_err_zero, aclk, aresetn, err_word, m_tdata[VALUE_W-1:0] == '0)

    // A failed operation always gives a single, final result.
    `SIA_ASSERT_NOW(a_err_last, aclk, aresetn, err_word, m_tlast)

    // Occupancy never exceeds capacity while it fits the field.
    `SIA_ASSERT_NOW(a_occ_range, aclk, aresetn, m_tvalid && (DEPTH < 32),
                    m_tdata[VALUE_W+OCC_W-1:VALUE_W] <= OCC_W'(DEPTH))

    // A stalled result word is held.
    `SIA_ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready,
                     m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

    // An offered word is not taken while a result word is stalled.
    `SIA_ASSERT_NOW(a_stall_in, aclk, aresetn, s_tvalid && m_tvalid && !m_tready, !s_tready)

endmodule

bind shift_insert_array sia_checker #(
    .DEPTH (DEPTH)
) u_sia_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
